// File: hdl/ffeud_pkg.sv
package ffeud_pkg;

	// window and key limits
	localparam int WIN_DEPTH = 8;
	localparam int KEY_MAX   = 8;
	localparam int KEY_W     = 64;
	localparam int KLEN_W    = 4;
	localparam int FILL_W    = 4;
	localparam int BYTE_W    = 8;
	localparam int REG_IDX_W = 1;

	// register indexes on the write port
	localparam logic [REG_IDX_W-1:0] REG_KEY_CHARS  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 1'b1;

	// special characters
	localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	// parser phase
	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_SKIP,
		PH_VALUE,
		PH_PCT1,
		PH_PCT2,
		PH_DONE
	} phase_t;

	// window control from the parser
	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctrl_t;

	// one result item
	typedef struct packed {
		logic [BYTE_W-1:0] value_byte;
		logic              byte_valid;
		logic              value_done;
		logic              key_found;
		logic              escape_error;
		logic              value_truncated;
	} result_t;

	// decoded hex digit
	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// hex digit decode, either case
	function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = c[3:0];
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			h.val = c[3:0] + 4'd9;
		end else begin
			h.ok  = 1'b0;
			h.val = 4'd0;
		end
		return h;
	endfunction

endpackage

// File: hdl/form_field_extract_url_decode.sv
// Form field extractor with percent decoding. Body bytes enter on the s_ side, one per
// transaction, with s_tlast on the final byte. The block finds the first place in the
// body where the configured key (key_chars, key_length, written on the wr_ port) ends,
// skips the next byte, then sends each decoded value byte ('+' as space, %XY as a hex
// byte) up to MAX_VALUE bytes, and closes with one transaction with m_tlast set that
// carries key_found and the escape and truncation flags. It takes one byte per cycle
// while the output is not stalled: the key window compare and the phase update are
// combinational between the input register and the result register, and a result
// passes both in turn. Configuration may be written only while no byte is in flight.
module form_field_extract_url_decode #(
	parameter int MAX_VALUE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// body input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // body_byte
	input  logic        s_tlast,   // body_end
	// value output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // value_byte, key_found, escape_error, value_truncated, zeros
	output logic        m_tuser,   // byte_valid
	output logic        m_tlast,   // value_done
	// configuration writes
	input  logic        wr_en,
	input  logic [ffeud_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [ffeud_pkg::KEY_W-1:0]     wr_data
);

	logic [ffeud_pkg::KEY_W-1:0]  key_chars_q;
	logic [ffeud_pkg::KLEN_W-1:0] key_length_q;
	logic                         valid_s1;
	logic [ffeud_pkg::BYTE_W-1:0] byte_s1;
	logic                         end_s1;
	logic                         out_free;
	logic                         step;
	logic                         match;
	ffeud_pkg::win_ctrl_t         win_ctrl;
	ffeud_pkg::result_t           res;
	logic                         res_valid;
	ffeud_pkg::result_t           res_q;
	logic                         m_tvalid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_chars_q  <= '0;
			key_length_q <= ffeud_pkg::KLEN_W'(1);
		end else if (wr_en) begin
			case (wr_index)
				ffeud_pkg::REG_KEY_CHARS: key_chars_q <= wr_data;
				ffeud_pkg::REG_KEY_LENGTH: key_length_q <= wr_data[ffeud_pkg::KLEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// handshake between input register and result register
	assign out_free = !m_tvalid_q || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	ffeud_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (win_ctrl),
		.byte_in    (byte_s1),
		.key_chars  (key_chars_q),
		.key_length (key_length_q),
		.match      (match)
	);

	ffeud_decoder #(
		.MAX_VALUE (MAX_VALUE)
	) u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (byte_s1),
		.end_in    (end_s1),
		.match     (match),
		.ctrl      (win_ctrl),
		.result    (res),
		.res_valid (res_valid)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (step) begin
			m_tvalid_q <= res_valid;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b00000, res_q.value_truncated, res_q.escape_error,
		res_q.key_found, res_q.value_byte};
	assign m_tuser  = res_q.byte_valid;
	assign m_tlast  = res_q.value_done;

	// a transaction without a byte must close the value
	a_empty_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("result without byte and without done");

	// status flags only travel with the closing transaction
	a_flags_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[10:8] == 3'b000)
		else $error("status flags set before value end");

	// no byte means a zero data byte
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'h00)
		else $error("value byte set without byte_valid");

	// input side stalls only while the input register holds an item
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid_q && !m_tready)
		else $error("input stalled without a blocked item");

endmodule

// File: hdl/ffeud_window.sv
module ffeud_window (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ffeud_pkg::win_ctrl_t              ctrl,
	input  logic [ffeud_pkg::BYTE_W-1:0]      byte_in,
	input  logic [ffeud_pkg::KEY_W-1:0]       key_chars,
	input  logic [ffeud_pkg::KLEN_W-1:0]      key_length,
	output logic                              match
);

	logic [ffeud_pkg::BYTE_W-1:0] recent_q [ffeud_pkg::WIN_DEPTH];
	logic [ffeud_pkg::BYTE_W-1:0] win_next [ffeud_pkg::WIN_DEPTH];
	logic [ffeud_pkg::FILL_W-1:0] fill_q;
	logic [ffeud_pkg::FILL_W-1:0] fill_next;
	logic [ffeud_pkg::KLEN_W-1:0] klen;
	logic [2:0]                   klen_m1;
	logic [ffeud_pkg::WIN_DEPTH-1:0] lane_ok;

	// window as it stands once the new byte is in
	always_comb begin
		win_next[0] = byte_in;
		for (int j = 1; j < ffeud_pkg::WIN_DEPTH; j++) begin
			win_next[j] = recent_q[j-1];
		end
		fill_next = (fill_q == ffeud_pkg::FILL_W'(ffeud_pkg::WIN_DEPTH)) ?
			fill_q : fill_q + 1'b1;
	end

	// effective key length, clamped to 1..KEY_MAX
	always_comb begin
		if (key_length == '0) begin
			klen = ffeud_pkg::KLEN_W'(1);
		end else if (key_length > ffeud_pkg::KLEN_W'(ffeud_pkg::KEY_MAX)) begin
			klen = ffeud_pkg::KLEN_W'(ffeud_pkg::KEY_MAX);
		end else begin
			klen = key_length;
		end
		klen_m1 = 3'(klen - 1'b1);
	end

	// one comparator per window position, newest byte against last key byte
	always_comb begin
		logic [2:0] kidx;
		for (int j = 0; j < ffeud_pkg::WIN_DEPTH; j++) begin
			kidx = 3'(klen_m1 - 3'(j));
			lane_ok[j] = (3'(j) > klen_m1) ||
				(win_next[j] == key_chars[{kidx, 3'b000} +: ffeud_pkg::BYTE_W]);
		end
		match = (fill_next >= klen) && (&lane_ok);
	end

	// window bytes
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			for (int j = 0; j < ffeud_pkg::WIN_DEPTH; j++) begin
				recent_q[j] <= win_next[j];
			end
		end
	end

	// fill level, cleared at body end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctrl.clear) begin
			fill_q <= '0;
		end else if (ctrl.shift) begin
			fill_q <= fill_next;
		end
	end

endmodule

// File: hdl/ffeud_decoder.sv
module ffeud_decoder #(
	parameter int MAX_VALUE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [ffeud_pkg::BYTE_W-1:0]  byte_in,
	input  logic                          end_in,
	input  logic                          match,
	output ffeud_pkg::win_ctrl_t          ctrl,
	output ffeud_pkg::result_t            result,
	output logic                          res_valid
);

	localparam int CNT_W = $clog2(MAX_VALUE + 1);

	ffeud_pkg::phase_t            phase_q;
	ffeud_pkg::phase_t            phase_n;
	logic [3:0]                   hn_q;
	logic [3:0]                   hn_n;
	logic [CNT_W-1:0]             cnt_q;
	logic                         esc_q;
	logic                         trunc_q;
	ffeud_pkg::hex_t              hex;
	logic                         emit_req;
	logic [ffeud_pkg::BYTE_W-1:0] emit_data;
	logic                         esc_hex;
	logic                         done_amp;
	logic                         room;
	logic                         byte_ok;
	logic                         trunc_set;
	logic                         end_done;
	logic                         esc_end;
	logic                         done;
	logic                         found;

	assign hex = ffeud_pkg::hex_decode(byte_in);

	// window follows the stream only while searching
	assign ctrl.shift = step && (phase_q == ffeud_pkg::PH_SEARCH);
	assign ctrl.clear = step && end_in;

	// next phase and byte actions
	always_comb begin
		phase_n   = phase_q;
		hn_n      = hn_q;
		emit_req  = 1'b0;
		emit_data = byte_in;
		esc_hex   = 1'b0;
		done_amp  = 1'b0;
		case (phase_q)
			ffeud_pkg::PH_SEARCH: begin
				if (match) begin
					phase_n = ffeud_pkg::PH_SKIP;
				end
			end
			ffeud_pkg::PH_SKIP: begin
				phase_n = ffeud_pkg::PH_VALUE;
			end
			ffeud_pkg::PH_VALUE: begin
				if (byte_in == ffeud_pkg::CH_AMP) begin
					done_amp = 1'b1;
				end else if (byte_in == ffeud_pkg::CH_PLUS) begin
					emit_req  = 1'b1;
					emit_data = ffeud_pkg::CH_SPACE;
				end else if (byte_in == ffeud_pkg::CH_PCT) begin
					phase_n = ffeud_pkg::PH_PCT1;
				end else begin
					emit_req = 1'b1;
				end
			end
			ffeud_pkg::PH_PCT1, ffeud_pkg::PH_PCT2: begin
				if (!hex.ok) begin
					esc_hex = 1'b1;
					phase_n = ffeud_pkg::PH_VALUE;
					done_amp = (byte_in == ffeud_pkg::CH_AMP);
				end else if (phase_q == ffeud_pkg::PH_PCT1) begin
					hn_n    = hex.val;
					phase_n = ffeud_pkg::PH_PCT2;
				end else begin
					emit_req  = 1'b1;
					emit_data = {hn_q, hex.val};
					phase_n   = ffeud_pkg::PH_VALUE;
				end
			end
			default: begin
			end
		endcase
		if (done_amp) begin
			phase_n = ffeud_pkg::PH_DONE;
		end
	end

	// result of this byte
	always_comb begin
		room      = (cnt_q < CNT_W'(MAX_VALUE));
		byte_ok   = emit_req && room;
		trunc_set = emit_req && !room;
		end_done  = end_in && !done_amp && (phase_n != ffeud_pkg::PH_DONE);
		esc_end   = end_done &&
			((phase_n == ffeud_pkg::PH_PCT1) || (phase_n == ffeud_pkg::PH_PCT2));
		done      = done_amp || end_done;
		found     = done_amp || (end_done && (phase_n != ffeud_pkg::PH_SEARCH));

		result.value_byte      = byte_ok ? emit_data : '0;
		result.byte_valid      = byte_ok;
		result.value_done      = done;
		result.key_found       = done && found;
		result.escape_error    = done && (esc_q || esc_hex || esc_end);
		result.value_truncated = done && (trunc_q || trunc_set);
		res_valid              = byte_ok || done;
	end

	// parser state, back to reset at body end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ffeud_pkg::PH_SEARCH;
			hn_q    <= '0;
			cnt_q   <= '0;
			esc_q   <= 1'b0;
			trunc_q <= 1'b0;
		end else if (step) begin
			if (end_in) begin
				phase_q <= ffeud_pkg::PH_SEARCH;
				hn_q    <= '0;
				cnt_q   <= '0;
				esc_q   <= 1'b0;
				trunc_q <= 1'b0;
			end else begin
				phase_q <= phase_n;
				hn_q    <= hn_n;
				if (byte_ok) begin
					cnt_q <= cnt_q + 1'b1;
				end
				esc_q   <= esc_q || esc_hex;
				trunc_q <= trunc_q || trunc_set;
			end
		end
	end

endmodule

// File: test/form_field_extract_url_decode_tb.sv
module form_field_extract_url_decode_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_LIMIT   = 64;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_BYTES  = 1900;
	localparam int PHASE_BYTES   = 240;

	typedef logic [7:0] byte_q_t[$];

	// one row of the directed table
	typedef struct packed {
		logic [7:0]         b;
		logic               last;
		logic               fixed;
		logic               has;
		ffeud_pkg::result_t res;
	} dir_row_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        wr_en    = 1'b0;
	logic [ffeud_pkg::REG_IDX_W-1:0] wr_index = '0;
	logic [ffeud_pkg::KEY_W-1:0]     wr_data  = '0;

	// row travelling with the byte on offer
	dir_row_t cur_row = '0;

	// parser copy
	logic [7:0]        win [ffeud_pkg::WIN_DEPTH];
	int unsigned       win_fill;
	ffeud_pkg::phase_t ph;
	logic [3:0]        hi_nib;
	int unsigned       n_emitted;
	bit                esc_flag;
	bit                trunc_flag;
	logic [63:0]       key_reg = '0;
	logic [3:0]        klen_reg = 4'd1;

	ffeud_pkg::result_t expected_results[$];
	int unsigned mismatches = 0;
	int unsigned src_idle_pct = 23;
	int unsigned sink_idle_pct = 23;
	int unsigned hold_reqs = 0;
	int unsigned stall_cycles = 0;

	form_field_extract_url_decode #(.MAX_VALUE(VALUE_LIMIT)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_parser();
		for (int i = 0; i < ffeud_pkg::WIN_DEPTH; i++) win[i] = '0;
		win_fill   = 0;
		ph         = ffeud_pkg::PH_SEARCH;
		hi_nib     = '0;
		n_emitted  = 0;
		esc_flag   = 1'b0;
		trunc_flag = 1'b0;
	endfunction

	// zero acts as one, above the window acts as full window
	function automatic int unsigned key_len_eff();
		if (klen_reg == 4'd0) return 1;
		if (klen_reg > ffeud_pkg::KEY_MAX) return ffeud_pkg::KEY_MAX;
		return klen_reg;
	endfunction

	function automatic void hex_nib(input logic [7:0] c, output bit ok, output logic [3:0] v);
		ok = 1'b1;
		v  = '0;
		if (c >= "0" && c <= "9") v = 4'(c - "0");
		else if (c >= "A" && c <= "F") v = 4'(c - "A" + 10);
		else if (c >= "a" && c <= "f") v = 4'(c - "a" + 10);
		else ok = 1'b0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 10) return 8'("0" + v);
		return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
	endfunction

	// count a value byte, or mark the value truncated once the limit is reached
	function automatic void emit_byte(input logic [7:0] b, output bit valid,
	                                  output logic [7:0] vb);
		vb = b;
		valid = 1'b0;
		if (n_emitted < VALUE_LIMIT) begin
			n_emitted++;
			valid = 1'b1;
		end else begin
			trunc_flag = 1'b1;
		end
	endfunction

	// advance the parser copy by one body byte
	function automatic void parse_byte(input logic [7:0] b, input bit last, output bit has,
	                                   output ffeud_pkg::result_t r);
		bit          valid, done, found, ok, hit;
		logic [7:0]  vb;
		logic [3:0]  h;
		int unsigned n;
		valid = 1'b0;
		done  = 1'b0;
		found = 1'b0;
		vb    = '0;
		case (ph)
			ffeud_pkg::PH_SEARCH: begin
				for (int i = ffeud_pkg::WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
				win[0] = b;
				if (win_fill < ffeud_pkg::WIN_DEPTH) win_fill++;
				n = key_len_eff();
				hit = (win_fill >= n);
				for (int i = 0; i < n; i++)
					if (win[n-1-i] != key_reg[8*i +: 8]) hit = 1'b0;
				if (hit) ph = ffeud_pkg::PH_SKIP;
			end
			ffeud_pkg::PH_SKIP: ph = ffeud_pkg::PH_VALUE;
			ffeud_pkg::PH_VALUE: begin
				if (b == ffeud_pkg::CH_AMP) begin
					done  = 1'b1;
					found = 1'b1;
				end else if (b == ffeud_pkg::CH_PLUS) emit_byte(ffeud_pkg::CH_SPACE, valid, vb);
				else if (b == ffeud_pkg::CH_PCT) ph = ffeud_pkg::PH_PCT1;
				else emit_byte(b, valid, vb);
			end
			ffeud_pkg::PH_PCT1, ffeud_pkg::PH_PCT2: begin
				hex_nib(b, ok, h);
				if (!ok) begin
					esc_flag = 1'b1;
					ph = ffeud_pkg::PH_VALUE;
					if (b == ffeud_pkg::CH_AMP) begin
						done  = 1'b1;
						found = 1'b1;
					end
				end else if (ph == ffeud_pkg::PH_PCT1) begin
					hi_nib = h;
					ph = ffeud_pkg::PH_PCT2;
				end else begin
					emit_byte({hi_nib, h}, valid, vb);
					ph = ffeud_pkg::PH_VALUE;
				end
			end
			default: ;
		endcase
		// value end, or body end closing whatever is open
		if (done) ph = ffeud_pkg::PH_DONE;
		else if (last && ph != ffeud_pkg::PH_DONE) begin
			if (ph == ffeud_pkg::PH_PCT1 || ph == ffeud_pkg::PH_PCT2) esc_flag = 1'b1;
			done  = 1'b1;
			found = (ph != ffeud_pkg::PH_SEARCH);
		end
		r.value_byte      = valid ? vb : 8'h00;
		r.byte_valid      = valid;
		r.value_done      = done;
		r.key_found       = done && found;
		r.escape_error    = done && esc_flag;
		r.value_truncated = done && trunc_flag;
		has = valid || done;
		if (last) clear_parser();
	endfunction

	function automatic dir_row_t body_row(input logic [7:0] b, input bit last,
	                                      input bit fixed = 1'b0, input bit has = 1'b0,
	                                      input ffeud_pkg::result_t res = '0);
		dir_row_t row;
		row.b     = b;
		row.last  = last;
		row.fixed = fixed;
		row.has   = has;
		row.res   = res;
		return row;
	endfunction

	function automatic bit src_idle();
		return $urandom_range(99) < src_idle_pct;
	endfunction

	// offer one byte and hold it until the transaction completes
	task automatic send_byte(input dir_row_t row);
		if (src_idle()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while (src_idle()) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= row.b;
		s_tlast  <= row.last;
		cur_row  <= row;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// stop offering and wait until every result is out and the pipe is empty
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_key(input logic [63:0] chars, input logic [3:0] len);
		wr_en    <= 1'b1;
		wr_index <= ffeud_pkg::REG_KEY_CHARS;
		wr_data  <= chars;
		@(posedge clk);
		wr_index <= ffeud_pkg::REG_KEY_LENGTH;
		wr_data  <= {60'd0, len};
		@(posedge clk);
		wr_en    <= 1'b0;
		key_reg  = chars;
		klen_reg = len;
	endtask

	// one body: noise, then part of the key, or the key, separator, value, ending
	task automatic make_body(output byte_q_t q);
		int unsigned n, m, vlen, pick;
		bit          ok;
		logic [3:0]  v;
		logic [7:0]  c;
		q = {};
		n = key_len_eff();
		repeat ($urandom_range(2)) begin
			if ($urandom_range(1)) q.push_back(8'($urandom_range(255)));
			else begin
				q.push_back("x");
				q.push_back("=");
				q.push_back(8'($urandom_range("0", "9")));
				q.push_back(ffeud_pkg::CH_AMP);
			end
		end
		if ($urandom_range(99) < 15) begin
			// broken: only part of the key
			m = $urandom_range(n - 1);
			for (int i = 0; i < m; i++) q.push_back(key_reg[8*i +: 8]);
			q.push_back(8'($urandom_range(255)));
		end else begin
			for (int i = 0; i < n; i++) q.push_back(key_reg[8*i +: 8]);
			q.push_back($urandom_range(9) == 0 ? 8'($urandom_range(255)) : 8'h3D);
			vlen = ($urandom_range(9) == 0) ? $urandom_range(60, 72) : $urandom_range(10);
			repeat (vlen) begin
				pick = $urandom_range(99);
				if (pick < 50) q.push_back(8'($urandom_range(8'h30, 8'h7A)));
				else if (pick < 60) q.push_back(ffeud_pkg::CH_PLUS);
				else if (pick < 78) begin
					q.push_back(ffeud_pkg::CH_PCT);
					q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
					q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
				end else if (pick < 86) begin
					// bad escape digit in either position
					q.push_back(ffeud_pkg::CH_PCT);
					if ($urandom_range(1))
						q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
					do begin
						c = 8'($urandom_range(255));
						hex_nib(c, ok, v);
					end while (ok);
					q.push_back(c);
				end else q.push_back(8'($urandom_range(255)));
			end
			case ($urandom_range(3))
				0: begin
					q.push_back(ffeud_pkg::CH_AMP);
					repeat ($urandom_range(3)) q.push_back(8'($urandom_range(255)));
				end
				1: begin
					q.push_back(ffeud_pkg::CH_PCT);
					if ($urandom_range(1))
						q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
				end
				default: ;
			endcase
		end
	endtask

	// check both sides on each edge
	always @(posedge clk) begin : monitor
		bit                 has;
		ffeud_pkg::result_t r;
		ffeud_pkg::result_t want;
		ffeud_pkg::result_t got;
		if (s_tvalid && s_tready) begin
			parse_byte(s_tdata, s_tlast, has, r);
			if (cur_row.fixed) begin
				has = cur_row.has;
				r   = cur_row.res;
			end
			if (has) expected_results.push_back(r);
		end
		if (m_tvalid && m_tready) begin
			got.value_byte      = m_tdata[7:0];
			got.byte_valid      = m_tuser;
			got.value_done      = m_tlast;
			got.key_found       = m_tdata[8];
			got.escape_error    = m_tdata[9];
			got.value_truncated = m_tdata[10];
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: tdata %h tuser %b tlast %b",
					         m_tdata, m_tuser, m_tlast);
			end else begin
				want = expected_results.pop_front();
				if (got !== want || m_tdata[15:11] !== 5'd0) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected byte %h valid %b done %b found %b ",
						          "esc %b trunc %b, got byte %h valid %b done %b found %b ",
						          "esc %b trunc %b pad %b"},
						         want.value_byte, want.byte_valid, want.value_done,
						         want.key_found, want.escape_error, want.value_truncated,
						         got.value_byte, got.byte_valid, got.value_done,
						         got.key_found, got.escape_error, got.value_truncated,
						         m_tdata[15:11]);
				end
			end
		end
	end

	// stall watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else stall_cycles <= stall_cycles + 1;
	end

	// result side: random idling, plus long hold-offs on request
	initial begin : sink
		int unsigned hold_left;
		int unsigned holds_done;
		hold_left  = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_done) begin
				holds_done = hold_reqs;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	initial begin : stimulus
		dir_row_t    dir_rows[$];
		byte_q_t     q;
		int unsigned total;
		int unsigned phase_cnt;
		int unsigned ph_idx;
		bit          held;
		logic [63:0] chars;
		logic [3:0]  len;
		clear_parser();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, key "ab"
		set_key(64'h6261, 4'd2);
		dir_rows.push_back(body_row("x", 1, 1, 1, {8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}));
		dir_rows.push_back(body_row("a", 0));
		dir_rows.push_back(body_row("b", 0));
		dir_rows.push_back(body_row("=", 0));
		dir_rows.push_back(body_row(8'h00, 0, 1, 1, {8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}));
		dir_rows.push_back(body_row(ffeud_pkg::CH_PLUS, 0));
		dir_rows.push_back(body_row(ffeud_pkg::CH_PCT, 0));
		dir_rows.push_back(body_row("4", 0));
		dir_rows.push_back(body_row("1", 0));
		dir_rows.push_back(body_row(ffeud_pkg::CH_PCT, 0));
		dir_rows.push_back(body_row("f", 0));
		dir_rows.push_back(body_row("F", 0, 1, 1, {8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}));
		dir_rows.push_back(body_row(ffeud_pkg::CH_PCT, 0));
		dir_rows.push_back(body_row("g", 0, 1, 0));
		dir_rows.push_back(body_row(ffeud_pkg::CH_AMP, 0, 1, 1,
		                            {8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}));
		dir_rows.push_back(body_row("z", 0, 1, 0));
		dir_rows.push_back(body_row("q", 1, 1, 0));
		// body ends on the last key byte
		dir_rows.push_back(body_row("a", 0));
		dir_rows.push_back(body_row("b", 1));
		// escape cut off by the body end
		dir_rows.push_back(body_row("a", 0));
		dir_rows.push_back(body_row("b", 0));
		dir_rows.push_back(body_row("=", 0));
		dir_rows.push_back(body_row(ffeud_pkg::CH_PCT, 0));
		dir_rows.push_back(body_row("4", 1, 1, 1, {8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}));
		foreach (dir_rows[i]) send_byte(dir_rows[i]);
		wait_idle();

		// random phases, each with its own key setting
		total  = 0;
		ph_idx = 0;
		while (total < RANDOM_BYTES) begin
			case (ph_idx % 6)
				0: begin
					chars = {$urandom, $urandom};
					len   = 4'd0;
				end
				1: begin
					chars = '1;
					len   = 4'd15;
				end
				2: begin
					chars = '0;
					len   = 4'd1;
				end
				default: begin
					for (int i = 0; i < 8; i++) chars[8*i +: 8] = 8'($urandom_range("a", "f"));
					len = (ph_idx % 6 == 3) ? 4'd8 : 4'($urandom_range(1, 8));
				end
			endcase
			set_key(chars, len);
			// no idling on either side for one whole phase
			if (ph_idx == 2) begin
				src_idle_pct  = 0;
				sink_idle_pct <= 0;
			end
			phase_cnt = 0;
			held = 1'b0;
			while (phase_cnt < PHASE_BYTES) begin
				if (ph_idx == 4 && !held && phase_cnt > 60) begin
					hold_reqs <= hold_reqs + 1;
					held = 1'b1;
				end
				make_body(q);
				foreach (q[i]) send_byte(body_row(q[i], i == q.size() - 1));
				phase_cnt += q.size();
			end
			total += phase_cnt;
			wait_idle();
			src_idle_pct  = 23;
			sink_idle_pct <= 23;
			ph_idx++;
		end

		if (mismatches == 0 && expected_results.size() == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
hdl/ffeud_pkg.sv
hdl/ffeud_window.sv
hdl/ffeud_decoder.sv
hdl/form_field_extract_url_decode.sv
test/form_field_extract_url_decode_tb.sv
